### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds in a cycle, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, codes and constants of the checksummed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

    localparam int unsigned DEFAULT_MAX_FRAME_LEN = 4096;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned FRAME_LEN_W = 13;
    localparam int unsigned LEN_ACC_W   = 32;

    localparam logic [BYTE_W-1:0] SYNC_BYTE0  = 8'h89;
    localparam logic [BYTE_W-1:0] SYNC_BYTE1  = 8'h98;
    localparam logic [BYTE_W-1:0] TRAIL_BYTE0 = 8'hAE;
    localparam logic [BYTE_W-1:0] TRAIL_BYTE1 = 8'hEA;

    // Header, type, checksum and end mark make up the fixed overhead.
    localparam logic [LEN_ACC_W-1:0] MIN_FRAME_LEN = 32'd10;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HEADER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRAIL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CHECK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LENGTH = 3'd4;

    localparam logic ITEM_BODY   = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    localparam int unsigned OUT_DATA_W = 40;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_SYNC2  = 8'b0000_0010,
        PH_LEN    = 8'b0000_0100,
        PH_TYPE   = 8'b0000_1000,
        PH_BODY   = 8'b0001_0000,
        PH_CHECK  = 8'b0010_0000,
        PH_TRAIL1 = 8'b0100_0000,
        PH_TRAIL2 = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } in_beat_t;

    typedef struct packed {
        logic                   item_kind;
        logic [BYTE_W-1:0]      body_byte;
        logic [STATUS_W-1:0]    frame_status;
        logic [BYTE_W-1:0]      frame_type;
        logic [FRAME_LEN_W-1:0] frame_length;
        logic [BYTE_W-1:0]      received_check;
    } result_t;

    function automatic result_t make_status(input logic [STATUS_W-1:0]    status,
                                            input logic [BYTE_W-1:0]      ftype,
                                            input logic [FRAME_LEN_W-1:0] flen,
                                            input logic [BYTE_W-1:0]      chk);
        result_t r;
        r.item_kind      = ITEM_STATUS;
        r.body_byte      = '0;
        r.frame_status   = status;
        r.frame_type     = ftype;
        r.frame_length   = flen;
        r.received_check = chk;
        return r;
    endfunction

    function automatic result_t make_body(input logic [BYTE_W-1:0] b);
        result_t r;
        r                = '0;
        r.item_kind      = ITEM_BODY;
        r.body_byte      = b;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/checksummed_frame_deframer.sv
// ----------------------------------------------------------------------------
// checksummed_frame_deframer
// Byte-stream deframer with start/end marks, length, type and additive sum.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the s_ channel, one byte per beat, with
// s_tuser high on byte 0 of each frame; a high s_tuser always restarts parsing
// and silently drops a partial frame. Body bytes leave on the m_ channel with
// m_tlast low, one beat per body byte, and every frame that is not dropped
// ends with one status beat (m_tlast high) that carries the status, type,
// saturated length and received checksum. Header bytes, checksum and end
// mark produce no beat.
// An accepted input beat is held in the input register and its result beat
// in the result register, with a single pass of compare and 8-bit add
// between them. A beat can be accepted every cycle.
// A stall on m_tready holds the result beat; the input register still takes
// one more beat, and s_tready drops only when both registers are full.
// Reset marks both registers empty and puts the parser idle, waiting for a frame
// start; bytes without a frame start while idle are discarded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module checksummed_frame_deframer #(
    parameter int unsigned MAX_FRAME_LEN = cfd_pkg::DEFAULT_MAX_FRAME_LEN
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] body_byte, [10:8] frame_status, [18:11] frame_type,
    // [31:19] frame_length, [39:32] received_check
    output logic [39:0]      m_tdata,
    output logic             m_tlast    // item_kind: 1 on the status beat
);
    import cfd_pkg::*;

    logic     beat_valid;
    in_beat_t beat;
    logic     can_accept;
    logic     go;
    logic     res_valid;
    result_t  res;

    assign go = beat_valid && can_accept;

    cfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (can_accept),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    cfd_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    cfd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .can_accept (can_accept),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Backpressure reaches the input only when both registers hold a beat.
    `ASSERT_IMPLIES(a_ready_only_when_full, !s_tready, beat_valid && m_tvalid && !m_tready, "s_tready low while a register has room")

    // A body beat carries nothing but its byte.
    `ASSERT_IMPLIES(a_body_fields_zero, m_tvalid && !m_tlast, m_tdata[39:8] == 32'd0, "body beat carries status fields")

    // The reported length never exceeds the configured maximum.
    `ASSERT_IMPLIES(a_length_saturated, m_tvalid && m_tlast, 32'(m_tdata[31:19]) <= 32'(MAX_FRAME_LEN), "status length above maximum")

endmodule

`default_nettype wire

### rtl/core/cfd_in_reg.sv
// ----------------------------------------------------------------------------
// cfd_in_reg
// Input register: captures one received beat and holds it for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_in_reg (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] rx_byte
    input  wire logic                     s_tuser,   // [0] frame_start
    input  wire logic                     take,
    output logic                          beat_valid,
    output cfd_pkg::in_beat_t             beat
);
    import cfd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;
    in_beat_t beat_next;

    // The held beat leaves whenever the parser can move it on.
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next            = 1'b1;
            beat_next.rx_byte     = s_tdata;
            beat_next.frame_start = s_tuser;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

### rtl/core/cfd_parser.sv
// ----------------------------------------------------------------------------
// cfd_parser
// Frame state machine: checks marks, gathers length and type, sums the body.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_parser #(
    parameter int unsigned MAX_FRAME_LEN = cfd_pkg::DEFAULT_MAX_FRAME_LEN
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire cfd_pkg::in_beat_t beat,
    output logic                   res_valid,
    output cfd_pkg::result_t       res
);
    import cfd_pkg::*;

    localparam int unsigned REM_W = $clog2(MAX_FRAME_LEN);
    localparam logic [LEN_ACC_W-1:0] LenMax = LEN_ACC_W'(MAX_FRAME_LEN);

    phase_t               phase_reg,   phase_next;
    logic [1:0]           len_idx_reg, len_idx_next;
    logic [LEN_ACC_W-1:0] length_reg,  length_next;
    logic [BYTE_W-1:0]    type_reg,    type_next;
    logic [BYTE_W-1:0]    sum_reg,     sum_next;
    logic [BYTE_W-1:0]    check_reg,   check_next;
    logic                 trail_ok_reg, trail_ok_next;
    logic [REM_W-1:0]     remain_reg,  remain_next;

    logic [LEN_ACC_W-1:0]   length_sat;
    logic [FRAME_LEN_W-1:0] length_out;
    logic [LEN_ACC_W-1:0]   body_len;
    logic [BYTE_W-1:0]      b;

    assign b          = beat.rx_byte;
    assign length_sat = (length_reg > LenMax) ? LenMax : length_reg;
    assign length_out = length_sat[FRAME_LEN_W-1:0];
    assign body_len   = length_reg - MIN_FRAME_LEN;

    always_comb
    begin
        phase_next    = phase_reg;
        len_idx_next  = len_idx_reg;
        length_next   = length_reg;
        type_next     = type_reg;
        sum_next      = sum_reg;
        check_next    = check_reg;
        trail_ok_next = trail_ok_reg;
        remain_next   = remain_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (go)
        begin
            if (beat.frame_start)
            begin
                // A start mark drops any partial frame and parses byte 0 afresh.
                phase_next    = PH_SYNC2;
                len_idx_next  = '0;
                length_next   = '0;
                type_next     = '0;
                sum_next      = '0;
                check_next    = '0;
                trail_ok_next = 1'b0;
                remain_next   = '0;
                if (b != SYNC_BYTE0)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res        = make_status(ST_HEADER, '0, '0, '0);
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_SYNC2:
                    begin
                        if (b != SYNC_BYTE1)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res = make_status(ST_HEADER, type_reg, length_out, check_reg);
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        length_next[{len_idx_reg, 3'b000} +: BYTE_W] =
                            length_reg[{len_idx_reg, 3'b000} +: BYTE_W] | b;
                        len_idx_next = len_idx_reg + 2'd1;
                        if (len_idx_reg == 2'd3)
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next = b;
                        if (length_reg < MIN_FRAME_LEN || length_reg > LenMax)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res = make_status(ST_LENGTH, b, length_out, check_reg);
                        end
                        else
                        begin
                            remain_next = body_len[REM_W-1:0];
                            phase_next  = (length_reg == MIN_FRAME_LEN) ? PH_CHECK : PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        sum_next    = sum_reg + b;
                        remain_next = remain_reg - REM_W'(1);
                        if (remain_reg == REM_W'(1))
                        begin
                            phase_next = PH_CHECK;
                        end
                        res_valid = 1'b1;
                        res       = make_body(b);
                    end
                    PH_CHECK:
                    begin
                        check_next = b;
                        phase_next = PH_TRAIL1;
                    end
                    PH_TRAIL1:
                    begin
                        trail_ok_next = (b == TRAIL_BYTE0);
                        phase_next    = PH_TRAIL2;
                    end
                    PH_TRAIL2:
                    begin
                        // A bad end mark is reported ahead of a checksum mismatch.
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        if (!(trail_ok_reg && b == TRAIL_BYTE1))
                        begin
                            res = make_status(ST_TRAIL, type_reg, length_out, check_reg);
                        end
                        else if (sum_reg != check_reg)
                        begin
                            res = make_status(ST_CHECK, type_reg, length_out, check_reg);
                        end
                        else
                        begin
                            res = make_status(ST_OK, type_reg, length_out, check_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            len_idx_reg  <= '0;
            length_reg   <= '0;
            type_reg     <= '0;
            sum_reg      <= '0;
            check_reg    <= '0;
            trail_ok_reg <= 1'b0;
            remain_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            len_idx_reg  <= len_idx_next;
            length_reg   <= length_next;
            type_reg     <= type_next;
            sum_reg      <= sum_next;
            check_reg    <= check_next;
            trail_ok_reg <= trail_ok_next;
            remain_reg   <= remain_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cfd_out_reg.sv
// ----------------------------------------------------------------------------
// cfd_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    input  wire cfd_pkg::result_t res,
    output logic                  can_accept,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [7:0] body_byte, [10:8] frame_status, [18:11] frame_type,
    // [31:19] frame_length, [39:32] received_check
    output logic [39:0]           m_tdata,
    output logic                  m_tlast    // item_kind: 1 on the status beat
);
    import cfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    assign can_accept = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (can_accept)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = data_reg.item_kind;
    assign m_tdata  = {data_reg.received_check, data_reg.frame_length,
                       data_reg.frame_type, data_reg.frame_status, data_reg.body_byte};

endmodule

`default_nettype wire
